### hw/rtl/crfr_pkg.sv
`default_nettype none

package crfr_pkg;

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhStart = 2'd1,
    PhData  = 2'd2,
    PhSum   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StatusGood   = 2'd0,
    StatusSumErr = 2'd1,
    StatusIdErr  = 2'd2
  } status_e;

  localparam logic [7:0] HeadMark  = 8'hFF;
  localparam logic [7:0] StartMark = 8'h02;

  localparam int unsigned MaxRecords = 8;

endpackage

`default_nettype wire

### hw/rtl/checksummed_record_frame_receiver_core.sv
`default_nettype none

// Byte-stream frame receiver. A frame is head byte 0xFF, then 0x02, then RECORDS records of
// five bytes (an id byte and a big-endian 32-bit word), then one checksum byte equal to the
// 8-bit sum of every earlier frame byte. A wrong byte after the head sends the parser back to
// hunting, and that byte is not taken as a new head. Each record word is staged in the slot
// its id names; an id at or above RECORDS is discarded and flags the frame. When the checksum
// matches, every staged word becomes a held word. Each completed frame gives one result:
// status 0 good, 1 checksum mismatch (held words unchanged), 2 bad record id with a matching
// checksum, together with held words 0 and 1 (word one reads zero when RECORDS is 1). A
// byte can be taken in every cycle. The single result register limits that rate:
// rx_byte_ready_o is low only while a result is waiting and out_ready_i is low.
module checksummed_record_frame_receiver_core
  import crfr_pkg::*;
#(
  parameter int unsigned RECORDS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_byte_valid_i,
  output logic             rx_byte_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       frame_status_o,
  output logic [31:0]      word_zero_o,
  output logic [31:0]      word_one_o
);

  localparam int unsigned CntW = $clog2(RECORDS + 1);

  phase_e          phase_q, phase_d;
  logic [2:0]      pos_q, pos_d;
  logic [CntW-1:0] rec_cnt_q, rec_cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      cur_id_q, cur_id_d;
  logic            id_fault_q, id_fault_d;
  logic [31:0]     staged_q [RECORDS];
  logic [31:0]     held_q   [RECORDS];
  logic [RECORDS-1:0] stage_we;
  logic            held_we;

  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [31:0]     word_zero_q, word_one_q;

  logic            in_xfer;
  logic            emit;
  logic            sum_ok;
  logic            id_ok;
  logic            cur_ok;
  logic [1:0]      status_d;
  logic [31:0]     word_zero_d, word_one_d;

  assign rx_byte_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer         = rx_byte_valid_i && rx_byte_ready_o;

  assign id_ok  = ({24'd0, rx_byte_i} < 32'(RECORDS));
  assign cur_ok = ({24'd0, cur_id_q} < 32'(RECORDS));
  assign sum_ok = (rx_byte_i == sum_q);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    rec_cnt_d  = rec_cnt_q;
    sum_d      = sum_q;
    cur_id_d   = cur_id_q;
    id_fault_d = id_fault_q;
    stage_we   = '0;
    held_we    = 1'b0;
    emit       = 1'b0;
    if (in_xfer) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == HeadMark) begin
            sum_d   = HeadMark;
            phase_d = PhStart;
          end
        end
        PhStart: begin
          if (rx_byte_i == StartMark) begin
            sum_d      = sum_q + StartMark;
            pos_d      = '0;
            rec_cnt_d  = '0;
            id_fault_d = 1'b0;
            phase_d    = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          sum_d = sum_q + rx_byte_i;
          if (pos_q == 3'd0) begin
            cur_id_d = rx_byte_i;
            if (!id_ok) begin
              id_fault_d = 1'b1;
            end
            pos_d = 3'd1;
          end else begin
            for (int unsigned k = 0; k < RECORDS; k++) begin
              stage_we[k] = cur_ok && ({24'd0, cur_id_q} == 32'(k));
            end
            if (pos_q == 3'd4) begin
              pos_d     = '0;
              rec_cnt_d = rec_cnt_q + 1'b1;
              if (32'(rec_cnt_q) + 32'd1 >= 32'(RECORDS)) begin
                phase_d = PhSum;
              end
            end else begin
              pos_d = pos_q + 3'd1;
            end
          end
        end
        PhSum: begin
          phase_d = PhHunt;
          emit    = 1'b1;
          held_we = sum_ok;
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_comb begin
    if (!sum_ok) begin
      status_d = StatusSumErr;
    end else if (id_fault_q) begin
      status_d = StatusIdErr;
    end else begin
      status_d = StatusGood;
    end
    word_zero_d = held_we ? staged_q[0] : held_q[0];
    word_one_d  = '0;
    if (RECORDS > 1) begin
      word_one_d = held_we ? staged_q[RECORDS > 1 ? 1 : 0] : held_q[RECORDS > 1 ? 1 : 0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      pos_q      <= '0;
      rec_cnt_q  <= '0;
      sum_q      <= '0;
      cur_id_q   <= '0;
      id_fault_q <= 1'b0;
      for (int unsigned k = 0; k < RECORDS; k++) begin
        staged_q[k] <= '0;
        held_q[k]   <= '0;
      end
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rec_cnt_q  <= rec_cnt_d;
      sum_q      <= sum_d;
      cur_id_q   <= cur_id_d;
      id_fault_q <= id_fault_d;
      for (int unsigned k = 0; k < RECORDS; k++) begin
        if (stage_we[k]) begin
          staged_q[k] <= {staged_q[k][23:0], rx_byte_i};
        end
        if (held_we) begin
          held_q[k] <= staged_q[k];
        end
      end
    end
  end

  // hold the result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q    <= status_d;
      word_zero_q <= word_zero_d;
      word_one_q  <= word_one_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign word_zero_o    = word_zero_q;
  assign word_one_o     = word_one_q;

endmodule

`default_nettype wire
